/* rtl/dvsd_pkg.sv */
// Shared types and constants for the delta vector stream decoder.
package dvsd_pkg;

	localparam logic [7:0]  MAX_PART_INDEX = 8'd63;
	localparam logic [7:0]  SEL_MASK       = 8'h70;
	localparam logic [7:0]  PAD_FLAG       = 8'h80;
	localparam logic [7:0]  NIBBLE_MASK    = 8'h0f;
	localparam logic [15:0] PAD_DEFAULT    = 16'h5aa5;
	localparam int          GATHER_DEPTH   = 7;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RAW,
		PH_CTRL,
		PH_DATA
	} phase_t;

	// Forms selected by control bits 6:4
	typedef enum logic [2:0] {
		FORM_ZERO,
		FORM_X4,
		FORM_Y4,
		FORM_Z4,
		FORM_XYZ4,
		FORM_767,
		FORM_999,
		FORM_12
	} form_t;

	typedef logic [GATHER_DEPTH-1:0][7:0] gbytes_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       frame_start;
		logic       raw_header;
	} byte_req_t;

	typedef struct packed {
		logic [5:0]         part_index;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] vec_z;
		logic [15:0]        pad_word;
		logic               last_part;
	} part_req_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [15:0]        pad;
	} vec_t;

endpackage

/* rtl/dvsd_decode.sv */
// Variable-length part decoder: control byte plus gathered bytes to a vector.
module dvsd_decode (
	input  logic [7:0]       ctrl,
	input  dvsd_pkg::gbytes_t bytes,
	input  logic             first_part,
	output dvsd_pkg::vec_t   vec
);

	logic [2:0] sel;
	logic [2:0] dl;
	logic [6:0] f7x;
	logic [5:0] f6y;
	logic [6:0] f7z;
	logic [8:0] f9x;
	logic [8:0] f9y;
	logic [8:0] f9z;
	logic [11:0] f12x;
	logic [11:0] f12y;
	logic [11:0] f12z;
	logic [15:0] nib;

	assign sel = 3'((ctrl & dvsd_pkg::SEL_MASK) >> 4);
	assign dl  = (sel >= 3'd4) ? sel - 3'd3 : 3'd0;
	assign nib = {{12{ctrl[3]}}, ctrl[3:0]};

	assign f7x  = {ctrl[3:0], bytes[0][7:5]};
	assign f6y  = {bytes[0][4:0], bytes[1][7]};
	assign f7z  = bytes[1][6:0];
	assign f9x  = {ctrl[3:0], bytes[0][7:3]};
	assign f9y  = {bytes[0][2:0], bytes[1][7:2]};
	assign f9z  = {bytes[1][1:0], bytes[2][7:1]};
	assign f12x = {ctrl[3:0], bytes[0]};
	assign f12y = {bytes[1], bytes[2][7:4]};
	assign f12z = {bytes[2][3:0], bytes[3]};

	always_comb begin
		vec.x = '0;
		vec.y = '0;
		vec.z = '0;
		case (dvsd_pkg::form_t'(sel))
			dvsd_pkg::FORM_ZERO: begin
			end
			dvsd_pkg::FORM_X4: vec.x = nib;
			dvsd_pkg::FORM_Y4: vec.y = nib;
			dvsd_pkg::FORM_Z4: vec.z = nib;
			dvsd_pkg::FORM_XYZ4: begin
				vec.x = nib;
				vec.y = {{12{bytes[0][7]}}, bytes[0][7:4]};
				vec.z = {{12{bytes[0][3]}}, bytes[0][3:0]};
			end
			dvsd_pkg::FORM_767: begin
				vec.x = {{9{f7x[6]}}, f7x};
				vec.y = {{10{f6y[5]}}, f6y};
				vec.z = {{9{f7z[6]}}, f7z};
			end
			dvsd_pkg::FORM_999: begin
				vec.x = {{7{f9x[8]}}, f9x};
				vec.y = {{7{f9y[8]}}, f9y};
				vec.z = {{7{f9z[8]}}, f9z};
			end
			default: begin
				vec.x = {{4{f12x[11]}}, f12x};
				vec.y = {{4{f12y[11]}}, f12y};
				vec.z = {{4{f12z[11]}}, f12z};
			end
		endcase

		// pad low byte follows the data bytes, high byte only on part 0
		if ((ctrl & dvsd_pkg::PAD_FLAG) != 8'h00) begin
			vec.pad = {8'h00, bytes[dl]};
			if (first_part) begin
				vec.pad[15:8] = bytes[dl + 3'd1];
			end
		end else begin
			vec.pad = dvsd_pkg::PAD_DEFAULT;
		end
	end

endmodule

/* rtl/delta_vector_stream_decoder_unit.sv */
// Top level of the delta vector stream decoder.
//
// Usage: bytes of a compressed frame stream enter on the byte channel, one
// request per byte (byte_valid/byte_stall, payload byte_data). A byte with
// frame_start set opens a new frame and aborts any frame in progress; with
// raw_header also set, part 0 is eight raw little-endian bytes. Bytes seen
// between frames are dropped. Each completed part leaves on the part channel
// (part_valid/part_stall, payload part_data), the final part of the frame
// flagged with last_part. The user writes part_count on the cfg channel only
// while the block is idle; the block does not enforce this. cfg_ready is always high.
// Throughput: one byte per cycle while byte_stall is low. Each byte updates
// the parse state in the cycle it is taken; the part it completes is registered
// into the output register, or into the skid register while the output stalls.
// A stalled output is held in the output register while one further result
// goes into a skid register; byte_stall rises only while the skid register
// is full, and falls as soon as the receiver drains it.
// Reset clears part_count, the parse state and both output valids; the block
// then waits for a frame_start byte.
module delta_vector_stream_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [5:0]          cfg_data,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  dvsd_pkg::byte_req_t byte_data,
	output logic                part_valid,
	input  logic                part_stall,
	output dvsd_pkg::part_req_t part_data
);

	dvsd_pkg::phase_t  phase_q, phase_n;
	logic [5:0]        part_q, part_n;
	logic [7:0]        ctrl_q, ctrl_n;
	logic [2:0]        cnt_q, cnt_n;
	logic [5:0]        part_count_q;
	dvsd_pkg::gbytes_t gath_q;

	logic              in_fire;
	logic              out_take;
	logic              out_valid_q;
	logic              skid_valid_q;
	dvsd_pkg::part_req_t out_q;
	dvsd_pkg::part_req_t skid_q;

	logic [5:0]        last_idx;
	logic [5:0]        part_eff;
	logic              g_we;
	logic [2:0]        g_idx;
	logic              do_emit;
	logic              use_raw;
	logic              is_last;
	logic              res_valid;
	dvsd_pkg::part_req_t res;
	logic [7:0]        dec_ctrl;
	dvsd_pkg::gbytes_t dec_bytes;
	dvsd_pkg::vec_t    dec_vec;
	logic [7:0]        v;

	function automatic logic [2:0] need_len(input logic [7:0] c, input logic first);
		logic [2:0] sel;
		logic [2:0] n;
		sel = 3'((c & dvsd_pkg::SEL_MASK) >> 4);
		n   = (sel >= 3'd4) ? sel - 3'd3 : 3'd0;
		if ((c & dvsd_pkg::PAD_FLAG) != 8'h00) begin
			n = n + (first ? 3'd2 : 3'd1);
		end
		return n;
	endfunction

	assign cfg_ready  = 1'b1;
	assign byte_stall = skid_valid_q;
	assign in_fire    = byte_valid && !byte_stall;
	assign out_take   = out_valid_q && !part_stall;
	assign part_valid = out_valid_q;
	assign part_data  = out_q;
	assign v          = byte_data.byte_value;

	assign last_idx = ({2'b00, part_count_q} > dvsd_pkg::MAX_PART_INDEX) ?
		dvsd_pkg::MAX_PART_INDEX[5:0] : part_count_q;
	assign part_eff = byte_data.frame_start ? 6'd0 : part_q;

	// replace the entry at the current count with the arriving byte
	always_comb begin
		for (int i = 0; i < dvsd_pkg::GATHER_DEPTH; i++) begin
			dec_bytes[i] = (3'(i) == cnt_q) ? v : gath_q[i];
		end
	end

	dvsd_decode u_decode (
		.ctrl       (dec_ctrl),
		.bytes      (dec_bytes),
		.first_part (part_eff == 6'd0),
		.vec        (dec_vec)
	);

	always_comb begin
		phase_n  = phase_q;
		part_n   = part_q;
		ctrl_n   = ctrl_q;
		cnt_n    = cnt_q;
		g_we     = 1'b0;
		g_idx    = cnt_q;
		do_emit  = 1'b0;
		use_raw  = 1'b0;
		dec_ctrl = ctrl_q;

		if (in_fire) begin
			if (byte_data.frame_start) begin
				part_n = 6'd0;
				cnt_n  = 3'd0;
				if (byte_data.raw_header) begin
					g_we    = 1'b1;
					g_idx   = 3'd0;
					cnt_n   = 3'd1;
					phase_n = dvsd_pkg::PH_RAW;
				end else begin
					dec_ctrl = v;
					ctrl_n   = v;
					if (need_len(v, 1'b1) == 3'd0) begin
						do_emit = 1'b1;
					end else begin
						phase_n = dvsd_pkg::PH_DATA;
					end
				end
			end else begin
				case (phase_q)
					dvsd_pkg::PH_RAW: begin
						if (cnt_q < 3'd7) begin
							g_we  = 1'b1;
							cnt_n = cnt_q + 3'd1;
						end else begin
							do_emit = 1'b1;
							use_raw = 1'b1;
						end
					end
					dvsd_pkg::PH_CTRL: begin
						dec_ctrl = v;
						ctrl_n   = v;
						cnt_n    = 3'd0;
						if (need_len(v, part_q == 6'd0) == 3'd0) begin
							do_emit = 1'b1;
						end else begin
							phase_n = dvsd_pkg::PH_DATA;
						end
					end
					dvsd_pkg::PH_DATA: begin
						if ({1'b0, cnt_q} + 4'd1 < {1'b0, need_len(ctrl_q, part_q == 6'd0)}) begin
							g_we  = 1'b1;
							cnt_n = cnt_q + 3'd1;
						end else begin
							do_emit = 1'b1;
						end
					end
					default: begin
						// drop bytes outside a frame
					end
				endcase
			end
		end

		is_last = part_eff >= last_idx;
		if (do_emit) begin
			cnt_n = 3'd0;
			if (is_last) begin
				phase_n = dvsd_pkg::PH_IDLE;
			end else begin
				part_n  = part_eff + 6'd1;
				phase_n = dvsd_pkg::PH_CTRL;
			end
		end

		res_valid      = do_emit;
		res.part_index = part_eff;
		res.last_part  = is_last;
		if (use_raw) begin
			res.vec_x    = {gath_q[1], gath_q[0]};
			res.vec_y    = {gath_q[3], gath_q[2]};
			res.vec_z    = {gath_q[5], gath_q[4]};
			res.pad_word = {v, gath_q[6]};
		end else begin
			res.vec_x    = dec_vec.x;
			res.vec_y    = dec_vec.y;
			res.vec_z    = dec_vec.z;
			res.pad_word = dec_vec.pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= dvsd_pkg::PH_IDLE;
			part_q       <= 6'd0;
			ctrl_q       <= 8'd0;
			cnt_q        <= 3'd0;
			part_count_q <= 6'd0;
		end else begin
			phase_q <= phase_n;
			part_q  <= part_n;
			ctrl_q  <= ctrl_n;
			cnt_q   <= cnt_n;
			if (cfg_valid && cfg_ready) begin
				part_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			gath_q[g_idx] <= v;
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a valid output");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last_part) |=> (phase_q == dvsd_pkg::PH_IDLE))
		else $error("parser not idle after last part");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dvsd_pkg::PH_DATA) |-> (cnt_q <= 3'd5))
		else $error("gather count past longest coded part");

	a_emit_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (cnt_q == 3'd0))
		else $error("gather count not cleared after a part");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the delta vector stream decoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0][7:0] bytes8_t;

	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 300;
	localparam int END_LIMIT    = 20000;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [5:0] cfg_data;
	logic      byte_valid;
	logic      byte_stall;
	dvsd_pkg::byte_req_t byte_data;
	logic      part_valid;
	logic      part_stall;
	dvsd_pkg::part_req_t part_data;

	// decoder shadow state
	logic [5:0] dec_part_count;
	dvsd_pkg::phase_t dec_phase;
	int         dec_part;
	logic [7:0] dec_ctrl;
	logic [7:0] dec_gather [dvsd_pkg::GATHER_DEPTH];
	int         dec_gcount;
	logic       dec_raw;

	dvsd_pkg::part_req_t parts_due [$];
	dvsd_pkg::byte_req_t stream_q [$];

	int idle_pct;
	int stall_pct;
	bit hold_armed;
	int errors;
	int bytes_used;

	delta_vector_stream_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.part_valid(part_valid),
		.part_stall(part_stall),
		.part_data (part_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sign_fill(input logic [15:0] v, input int bits);
		logic [15:0] mask;
		logic [15:0] r;
		mask = (16'd1 << bits) - 16'd1;
		r = v & mask;
		if (r[bits-1]) r = r | ~mask;
		return r;
	endfunction

	function automatic int last_idx();
		if ({2'b00, dec_part_count} < dvsd_pkg::MAX_PART_INDEX) return int'(dec_part_count);
		return int'(dvsd_pkg::MAX_PART_INDEX);
	endfunction

	function automatic int data_len(input logic [7:0] c);
		return (c[6:4] >= 3'd4) ? int'(c[6:4]) - 3 : 0;
	endfunction

	function automatic int need_len(input logic [7:0] c, input int part);
		int n;
		n = data_len(c);
		if (c[7]) n += (part == 0) ? 2 : 1;
		return n;
	endfunction

	function automatic void store_part(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [15:0] pad);
		dvsd_pkg::part_req_t p;
		int last;
		last = last_idx();
		p.part_index = dec_part[5:0];
		p.vec_x = x;
		p.vec_y = y;
		p.vec_z = z;
		p.pad_word = pad;
		p.last_part = (dec_part >= last);
		parts_due.push_back(p);
		if (dec_part >= last) begin
			dec_phase = dvsd_pkg::PH_IDLE;
		end else begin
			dec_part++;
			dec_phase = dvsd_pkg::PH_CTRL;
		end
		dec_gcount = 0;
	endfunction

	// b holds the data bytes followed by the pad bytes
	function automatic void decode_part(input bytes8_t b);
		logic [7:0] c;
		logic [15:0] x, y, z, pad;
		int dl;
		c = dec_ctrl;
		x = '0;
		y = '0;
		z = '0;
		dl = data_len(c);
		case (dvsd_pkg::form_t'(c[6:4]))
			dvsd_pkg::FORM_ZERO: ;
			dvsd_pkg::FORM_X4: x = sign_fill(16'(c[3:0]), 4);
			dvsd_pkg::FORM_Y4: y = sign_fill(16'(c[3:0]), 4);
			dvsd_pkg::FORM_Z4: z = sign_fill(16'(c[3:0]), 4);
			dvsd_pkg::FORM_XYZ4: begin
				x = sign_fill(16'(c[3:0]), 4);
				y = sign_fill(16'(b[0][7:4]), 4);
				z = sign_fill(16'(b[0][3:0]), 4);
			end
			dvsd_pkg::FORM_767: begin
				x = sign_fill(16'({c[3:0], b[0][7:5]}), 7);
				y = sign_fill(16'({b[0][4:0], b[1][7]}), 6);
				z = sign_fill(16'(b[1][6:0]), 7);
			end
			dvsd_pkg::FORM_999: begin
				x = sign_fill(16'({c[3:0], b[0][7:3]}), 9);
				y = sign_fill(16'({b[0][2:0], b[1][7:2]}), 9);
				z = sign_fill(16'({b[1][1:0], b[2][7:1]}), 9);
			end
			default: begin
				x = sign_fill(16'({c[3:0], b[0]}), 12);
				y = sign_fill(16'({b[1], b[2][7:4]}), 12);
				z = sign_fill(16'({b[2][3:0], b[3]}), 12);
			end
		endcase
		if (c[7]) begin
			pad = {8'h00, b[dl]};
			if (dec_part == 0) pad[15:8] = b[dl+1];
		end else begin
			pad = dvsd_pkg::PAD_DEFAULT;
		end
		store_part(x, y, z, pad);
	endfunction

	function automatic void take_control(input logic [7:0] v);
		dec_ctrl = v;
		dec_gcount = 0;
		if (need_len(v, dec_part) == 0) decode_part('0);
		else dec_phase = dvsd_pkg::PH_DATA;
	endfunction

	// Returns 1 unless the byte is dropped between frames.
	function automatic bit predict_byte(input dvsd_pkg::byte_req_t r);
		logic [7:0] v;
		bytes8_t b;
		int i;
		v = r.byte_value;
		if (r.frame_start) begin
			dec_raw = r.raw_header;
			dec_part = 0;
			dec_gcount = 0;
			if (dec_raw) begin
				dec_gather[0] = v;
				dec_gcount = 1;
				dec_phase = dvsd_pkg::PH_RAW;
			end else begin
				take_control(v);
			end
			return 1'b1;
		end
		case (dec_phase)
			dvsd_pkg::PH_RAW: begin
				if (dec_gcount < dvsd_pkg::GATHER_DEPTH) begin
					dec_gather[dec_gcount] = v;
					dec_gcount++;
				end else begin
					store_part({dec_gather[1], dec_gather[0]}, {dec_gather[3], dec_gather[2]},
						{dec_gather[5], dec_gather[4]}, {v, dec_gather[6]});
				end
			end
			dvsd_pkg::PH_CTRL: take_control(v);
			dvsd_pkg::PH_DATA: begin
				if (dec_gcount + 1 < need_len(dec_ctrl, dec_part) &&
						dec_gcount < dvsd_pkg::GATHER_DEPTH) begin
					dec_gather[dec_gcount] = v;
					dec_gcount++;
				end else begin
					b = '0;
					for (i = 0; i < dec_gcount && i < dvsd_pkg::GATHER_DEPTH; i++)
						b[i] = dec_gather[i];
					b[dec_gcount & 7] = v;
					decode_part(b);
				end
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic bit field_ok(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// part checker
	always @(posedge clk) begin
		dvsd_pkg::part_req_t want;
		bit ok;
		if (arst_n && part_valid && !part_stall) begin
			if (parts_due.size() == 0) begin
				$display("%0t: unexpected part, expected none got %h", $time, part_data);
				errors++;
			end else begin
				want = parts_due.pop_front();
				ok = field_ok("part_index", 16'(want.part_index), 16'(part_data.part_index))
					& field_ok("vec_x", want.vec_x, part_data.vec_x)
					& field_ok("vec_y", want.vec_y, part_data.vec_y)
					& field_ok("vec_z", want.vec_z, part_data.vec_z)
					& field_ok("pad_word", want.pad_word, part_data.pad_word)
					& field_ok("last_part", 16'(want.last_part), 16'(part_data.last_part));
				if (!ok) errors++;
			end
		end
	end

	// part receiver stall, with a counted long hold on request
	initial begin
		int n;
		part_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				for (n = 0; n < LONG_HOLD; n++) begin
					part_stall <= 1'b1;
					@(posedge clk);
				end
			end
			part_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_byte(input dvsd_pkg::byte_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= r;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		if (predict_byte(r)) bytes_used++;
	endtask

	task automatic push_byte(input logic [7:0] v, input logic fs, input logic rh);
		dvsd_pkg::byte_req_t r;
		r.byte_value = v;
		r.frame_start = fs;
		r.raw_header = rh;
		stream_q.push_back(r);
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0) send_byte(stream_q.pop_front());
	endtask

	task automatic write_part_count(input logic [5:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dec_part_count = v;
		cfg_valid <= 1'b0;
	endtask

	// Close any open frame, then drain all parts.
	task automatic settle();
		int i, last;
		if (dec_phase != dvsd_pkg::PH_IDLE) begin
			last = last_idx();
			push_byte(8'h00, 1'b1, 1'b0);
			for (i = 0; i < last; i++) push_byte(8'h00, 1'b0, 1'b0);
			send_stream();
		end
		byte_valid <= 1'b0;
		while (parts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_coded_part(input int part, input bit opens);
		logic [7:0] c;
		int n, i;
		c = 8'($urandom_range(255));
		n = need_len(c, part);
		push_byte(c, opens, opens ? 1'b0 : 1'($urandom_range(1)));
		for (i = 0; i < n; i++) push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
	endtask

	task automatic random_frame();
		int kind, last, p, keep, i;
		bit raw;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// junk: mostly dropped between frames, sometimes a stray frame start
			keep = $urandom_range(1, 4);
			for (i = 0; i < keep; i++)
				push_byte(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'($urandom_range(1)));
		end else begin
			raw = ($urandom_range(3) == 0);
			last = last_idx();
			p = 0;
			if (raw) begin
				push_byte(8'($urandom_range(255)), 1'b1, 1'b1);
				for (i = 0; i < 7; i++)
					push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
				p = 1;
			end
			for (; p <= last; p++) add_coded_part(p, (p == 0));
			// truncate some frames so the next frame start aborts them
			if (kind < 22) begin
				keep = $urandom_range(1, stream_q.size());
				while (stream_q.size() > keep) void'(stream_q.pop_back());
			end
		end
		send_stream();
	endtask

	task automatic test_directed_codes();
		idle_pct = 0;
		stall_pct = 0;
		write_part_count(6'd0);
		push_byte(8'ha5, 1'b0, 1'b1);                 // dropped while idle
		push_byte(8'h00, 1'b1, 1'b0);                 // all zero, default pad
		push_byte(8'h18, 1'b1, 1'b0);                 // x only, most negative
		push_byte(8'h27, 1'b1, 1'b0);                 // y only, most positive
		push_byte(8'h3f, 1'b1, 1'b0);                 // z only, -1
		push_byte(8'hc8, 1'b1, 1'b0);                 // 4-bit triple with two-byte pad
		push_byte(8'h7f, 1'b0, 1'b0);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h5f, 1'b1, 1'b0);                 // 7/6/7 fields, all ones
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h6f, 1'b1, 1'b0);                 // 9-bit form, aborted mid-frame
		push_byte(8'haa, 1'b0, 1'b0);
		push_byte(8'h78, 1'b1, 1'b0);                 // 12-bit extremes
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h7f, 1'b0, 1'b0);
		push_byte(8'hf8, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h01, 1'b1, 1'b1);                 // raw header is the last part
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h7f, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'ha5, 1'b0, 1'b0);
		push_byte(8'h5a, 1'b0, 1'b0);
		send_stream();
		settle();
	endtask

	task automatic test_random_stream(input int idle, input int stall, input logic [5:0] pc,
			input int budget);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		write_part_count(pc);
		target = bytes_used + budget;
		while (bytes_used < target) random_frame();
		settle();
	endtask

	// Hold the part channel for a long stretch while bytes keep coming.
	task automatic test_backpressure();
		int target;
		idle_pct = 0;
		stall_pct = 0;
		write_part_count(6'd63);
		hold_armed = 1'b1;
		target = bytes_used + 100;
		while (bytes_used < target) random_frame();
		settle();
	endtask

	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		byte_valid = 1'b0;
		byte_data = '0;
		errors = 0;
		bytes_used = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_armed = 1'b0;
		dec_part_count = '0;
		dec_phase = dvsd_pkg::PH_IDLE;
		dec_part = 0;
		dec_ctrl = '0;
		dec_gcount = 0;
		dec_raw = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_random_stream(0, 0, 6'd3, 400);
		test_random_stream(76, 0, 6'd63, 300);
		test_random_stream(0, 76, 6'd0, 300);
		test_random_stream(29, 29, 6'd9, 400);
		test_backpressure();

		byte_valid <= 1'b0;
		waited = 0;
		while (parts_due.size() != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (parts_due.size() != 0) begin
			$display("%0t: %0d parts expected but never produced", $time, parts_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
